// ===== hdl/sf17_pkg.sv =====
// ----------------------------------------------------------------------------
// sf17_pkg
// Types, widths and kernel tables of the 17x17 symmetric 2-D filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sf17_pkg;

  localparam int PIX_W   = 8;
  localparam int NPIX    = 17;
  localparam int FIELD_W = 32;
  localparam int NROW    = 9;
  localparam int NCOL    = 17;
  localparam int NQ      = 9;
  localparam int NSUM    = 32;

  localparam int FC_W  = 9;
  localparam int FQ_W  = 10;
  localparam int MS_W  = 11;
  localparam int PR_W  = 19;
  localparam int FP_W  = 20;
  localparam int L0_W  = 20;
  localparam int L1_W  = 21;
  localparam int L2_W  = 22;
  localparam int L3_W  = 23;
  localparam int OUT_W = 24;
  localparam int WT_W  = 8;

  typedef logic [PIX_W-1:0]              pix_t;
  typedef logic [FC_W-1:0]               fcol_t;
  typedef fcol_t [NROW-1:0]              column_t;
  typedef logic [FQ_W-1:0]               fq_t;
  typedef logic [MS_W-1:0]               msum_t;
  typedef logic signed [WT_W-1:0]        weight_t;
  typedef logic signed [PR_W-1:0]        prod_t;
  typedef logic signed [OUT_W-1:0]       result_t;

  localparam int PAIR_A [NSUM] = '{
    0, 1, 1, 1, 1, 2, 2, 2, 2, 2, 2, 3, 3, 3, 3, 3,
    3, 4, 4, 4, 4, 4, 5, 5, 5, 5, 6, 6, 6, 7, 7, 8
  };

  localparam int PAIR_B [NSUM] = '{
    8, 5, 6, 7, 8, 3, 4, 5, 6, 7, 8, 3, 4, 5, 6, 7,
    8, 4, 5, 6, 7, 8, 5, 6, 7, 8, 6, 7, 8, 7, 8, 8
  };

  localparam weight_t WEIGHTS [NSUM] = '{
    -8'sd106, -8'sd90,  -8'sd76,  -8'sd67,  -8'sd64,  -8'sd98,  -8'sd73,  -8'sd52,
    -8'sd36,  -8'sd26,  -8'sd22,  -8'sd67,  -8'sd39,  -8'sd15,   8'sd3,    8'sd14,
     8'sd18,  -8'sd8,    8'sd18,   8'sd37,   8'sd50,   8'sd54,   8'sd46,   8'sd67,
     8'sd80,   8'sd84,   8'sd89,   8'sd103,  8'sd108,  8'sd117,  8'sd122,  8'sd127
  };

endpackage

`default_nettype wire

// ===== hdl/sf17_if.sv =====
// ----------------------------------------------------------------------------
// sf17 channel interfaces
// Valid/ready channels for pixel columns and filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sf17_in_if;
  import sf17_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] rows_0_to_3;
  logic [FIELD_W-1:0] rows_4_to_7;
  logic [FIELD_W-1:0] rows_8_to_11;
  logic [FIELD_W-1:0] rows_12_to_15;
  logic [PIX_W-1:0]   row_16;

  modport source (
    output valid, rows_0_to_3, rows_4_to_7, rows_8_to_11, rows_12_to_15, row_16,
    input  ready
  );
  modport sink (
    input  valid, rows_0_to_3, rows_4_to_7, rows_8_to_11, rows_12_to_15, row_16,
    output ready
  );
endinterface

interface sf17_out_if;
  import sf17_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

`default_nettype wire

// ===== hdl/sf17_cell.sv =====
// ----------------------------------------------------------------------------
// sf17_cell
// One column of the folded window; passes its column on at each request.
// ----------------------------------------------------------------------------
`default_nettype none

module sf17_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire sf17_pkg::column_t d,
  output sf17_pkg::column_t      q
);
  import sf17_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sf17_fold.sv =====
// ----------------------------------------------------------------------------
// sf17_fold
// Column fold to the 9x9 quarter, mirrored sums and weight products.
// ----------------------------------------------------------------------------
`default_nettype none

module sf17_fold (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire sf17_pkg::column_t cols [sf17_pkg::NCOL],
  output sf17_pkg::prod_t        prod [sf17_pkg::NSUM]
);
  import sf17_pkg::*;

  fq_t   quarter      [NQ][NQ];
  fq_t   quarter_next [NQ][NQ];
  msum_t msum         [NSUM];
  msum_t msum_next    [NSUM];
  logic signed [FP_W-1:0] prod_full [NSUM];

  for (genvar r = 0; r < NROW; r++) begin : g_row
    for (genvar c = 0; c < NQ - 1; c++) begin : g_col
      assign quarter_next[r][c] = FQ_W'(cols[c][r]) + FQ_W'(cols[NCOL-1-c][r]);
    end
    assign quarter_next[r][NQ-1] = FQ_W'(cols[NQ-1][r]);
  end

  for (genvar i = 0; i < NSUM; i++) begin : g_sum
    localparam int A = PAIR_A[i];
    localparam int B = PAIR_B[i];
    if (A == B) begin : g_diag
      assign msum_next[i] = MS_W'(quarter[A][B]);
    end else begin : g_pair
      assign msum_next[i] = MS_W'(quarter[A][B]) + MS_W'(quarter[B][A]);
    end
    assign prod_full[i] = FP_W'($signed({1'b0, msum[i]})) * FP_W'(WEIGHTS[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NQ; r++) begin
        for (int c = 0; c < NQ; c++) begin
          quarter[r][c] <= '0;
        end
      end
      for (int i = 0; i < NSUM; i++) begin
        msum[i] <= '0;
        prod[i] <= '0;
      end
    end else if (en) begin
      quarter <= quarter_next;
      for (int i = 0; i < NSUM; i++) begin
        msum[i] <= msum_next[i];
        prod[i] <= prod_full[i][PR_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sf17_tree.sv =====
// ----------------------------------------------------------------------------
// sf17_tree
// Registered adder tree over the 32 products, final add left open.
// ----------------------------------------------------------------------------
`default_nettype none

module sf17_tree (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire sf17_pkg::prod_t prod [sf17_pkg::NSUM],
  output sf17_pkg::result_t    sum
);
  import sf17_pkg::*;

  logic signed [L0_W-1:0] l0 [16];
  logic signed [L1_W-1:0] l1 [8];
  logic signed [L2_W-1:0] l2 [4];
  logic signed [L3_W-1:0] l3 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) l0[k] <= '0;
      for (int k = 0; k < 8; k++)  l1[k] <= '0;
      for (int k = 0; k < 4; k++)  l2[k] <= '0;
      for (int k = 0; k < 2; k++)  l3[k] <= '0;
    end else if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) begin
          l0[j*4+i] <= L0_W'(prod[j*8+i]) + L0_W'(prod[j*8+4+i]);
        end
      end
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 4; i++) begin
          l1[j*4+i] <= L1_W'(l0[j*8+i]) + L1_W'(l0[j*8+4+i]);
        end
      end
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          l2[j*2+i] <= L2_W'(l1[j*4+i*2]) + L2_W'(l1[j*4+i*2+1]);
        end
      end
      for (int i = 0; i < 2; i++) begin
        l3[i] <= L3_W'(l2[i*2]) + L3_W'(l2[i*2+1]);
      end
    end
  end

  assign sum = OUT_W'(l3[0]) + OUT_W'(l3[1]);

endmodule

`default_nettype wire

// ===== hdl/symmetric_2d_filter_17x17.sv =====
// ----------------------------------------------------------------------------
// symmetric_2d_filter_17x17
// 17x17 filter with fourfold kernel symmetry, one image column per request.
// ----------------------------------------------------------------------------
// Takes one 17-pixel column per clock unless stalled and returns one signed
// 24-bit result per column. Every request advances the whole pipeline by one
// step: the row fold, a chain of 17 column cells, the quarter fold, mirrored
// sums, weight products and a four-level adder tree. The result returned for
// a column is the window sum of the column eight requests earlier, so the first
// eight results are zero and the window holds zero columns until 17 have
// entered. A request is taken whenever the output register is empty or is being
// read in the same cycle; the pipeline holds when the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_2d_filter_17x17 (
  input wire logic   clk,
  input wire logic   rst,
  sf17_in_if.sink    pixels,
  sf17_out_if.source result
);
  import sf17_pkg::*;

  logic    accept;
  logic    out_valid;
  result_t filtered;
  result_t sum;
  logic [NPIX*PIX_W-1:0] flat;
  pix_t    pix [NPIX];
  column_t new_col;
  column_t cols [NCOL];
  prod_t   prod [NSUM];

  assign pixels.ready = !out_valid || result.ready;
  assign accept       = pixels.valid && pixels.ready;

  assign flat = {pixels.row_16, pixels.rows_12_to_15, pixels.rows_8_to_11,
                 pixels.rows_4_to_7, pixels.rows_0_to_3};

  for (genvar p = 0; p < NPIX; p++) begin : g_pix
    assign pix[p] = flat[p*PIX_W +: PIX_W];
  end

  for (genvar r = 0; r < NROW - 1; r++) begin : g_rfold
    assign new_col[r] = FC_W'(pix[r]) + FC_W'(pix[NPIX-1-r]);
  end
  assign new_col[NROW-1] = FC_W'(pix[NROW-1]);

  for (genvar c = 0; c < NCOL; c++) begin : g_cell
    if (c == 0) begin : g_head
      sf17_cell u_cell (.clk(clk), .rst(rst), .en(accept), .d(new_col), .q(cols[c]));
    end else begin : g_body
      sf17_cell u_cell (.clk(clk), .rst(rst), .en(accept), .d(cols[c-1]), .q(cols[c]));
    end
  end

  sf17_fold u_fold (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .cols (cols),
    .prod (prod)
  );

  sf17_tree u_tree (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .prod (prod),
    .sum  (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      filtered <= sum;
    end
  end

  assign result.valid    = out_valid;
  assign result.filtered = filtered;

endmodule

`default_nettype wire

// ===== hdl/sf17_checker.sv =====
// ----------------------------------------------------------------------------
// sf17_checker
// Port-level checks of the filter's request flow, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sf17_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // no result may be shown right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // each taken column yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted column");

  // never take a column while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind symmetric_2d_filter_17x17 sf17_checker u_sf17_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (result.valid),
  .out_ready (result.ready)
);

`default_nettype wire
